// ----- hw/rtl/track_report_trigger_macros.svh -----
// Assertion macros used by track_report_trigger to check its own logic.
`ifndef TRACK_REPORT_TRIGGER_MACROS_SVH
`define TRACK_REPORT_TRIGGER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TRT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/trt_pkg.sv -----
package trt_pkg;

  localparam int unsigned BACKOFF_PERIOD_DEF = 20;
  localparam int unsigned SPEED_HYST         = 3;
  localparam int unsigned MOVING_SPEED       = 5;
  localparam int unsigned BACKOFF_MULT       = 30;
  localparam int unsigned RES_W              = $clog2(BACKOFF_MULT);
  localparam int unsigned IT_W               = 17;
  localparam int unsigned CFG_ADDR_W         = 5;
  localparam int unsigned CFG_DATA_W         = 32;

  localparam logic        TRACK_CTRL_RST     = 1'b0;
  localparam logic [9:0]  SPEED_LIMIT_RST    = 10'd1023;
  localparam logic [8:0]  HEADING_LIMIT_RST  = 9'd359;
  localparam logic [31:0] DISTANCE_LIMIT_RST = 32'hFFFF_FFFF;
  localparam logic [15:0] SEND_INTERVAL_RST  = 16'd5;

  typedef enum logic [2:0] {
    REG_TRACK_CTRL     = 3'd0,
    REG_SPEED_LIMIT    = 3'd1,
    REG_HEADING_LIMIT  = 3'd2,
    REG_DISTANCE_LIMIT = 3'd3,
    REG_SEND_INTERVAL  = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    CHG_NONE     = 2'd0,
    CHG_LOST     = 2'd1,
    CHG_REGAINED = 2'd2
  } chg_t;

  typedef struct packed {
    logic        fix_good;
    logic [9:0]  speed;
    logic [8:0]  heading;
    logic [31:0] odometer;
    logic        link_down;
    logic        hello_request;
  } trt_in_t;

  typedef struct packed {
    logic emit_report;
    logic speed_exceeded;
    logic course_changed;
    logic distance_passed;
    logic fix_lost;
    logic link_lost;
    chg_t fix_change;
    chg_t link_change;
  } trt_out_t;

endpackage

// ----- hw/rtl/trt_stream_if.sv -----
interface trt_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/track_report_trigger.sv -----
// Track report trigger.
// One word on in_ch is one half-second navigation tick (fix, speed, heading,
// odometer, link state, external report request). For every tick the block
// returns one word on out_ch: whether a position report is due, which track
// triggers fired, the fix and link levels and their loss or regain events.
// Both channels use valid/ready; a word moves when both are high.
// The tick is held in an input register, evaluated combinationally against the
// tracking state and written to the output register. One tick per cycle is
// sustained while out_ch takes every word; the state update for a tick
// completes in the cycle it moves into the output register, which is what
// lets the next tick follow directly.
// When out_ch stalls, the output register holds its word and the input
// register takes one more tick; in_ch.ready drops only when both are full.
// The cfg_ APB port writes the five registers at byte addresses 0, 4, 8, 12
// and 16 and reads them back; pready is always high. Write them only while
// no tick is in flight.
// Synchronous reset (rst_n low) empties both registers, clears all tracking
// state and returns the registers to their reset values.
module track_report_trigger
  import trt_pkg::*;
#(
  parameter int unsigned BACKOFF_PERIOD = BACKOFF_PERIOD_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  trt_stream_if.sink            in_ch,
  trt_stream_if.source          out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  `include "track_report_trigger_macros.svh"

  localparam int unsigned BT_W = (BACKOFF_PERIOD > 1) ? $clog2(BACKOFF_PERIOD + 1) : 1;

  // Configuration registers.
  logic        track_ctrl_r;
  logic [9:0]  speed_limit_r;
  logic [8:0]  heading_limit_r;
  logic [31:0] distance_limit_r;
  logic [15:0] send_interval_r;

  // Pipeline registers.
  logic     s1_valid_r;
  trt_in_t  s1_data_r;
  logic     out_valid_r;
  trt_out_t out_data_r;
  trt_out_t out_data_nxt;

  // Tracking state.
  logic             speed_latched_r, speed_latched_nxt;
  logic [8:0]       last_heading_r, last_heading_nxt;
  logic [31:0]      odo_mark_r, odo_mark_nxt;
  logic             fix_seen_r, fix_seen_nxt;
  logic             link_seen_r, link_seen_nxt;
  logic [BT_W-1:0]  bo_tick_r, bo_tick_nxt;
  logic [31:0]      bo_count_r, bo_count_nxt;
  logic [RES_W-1:0] bo_res_r, bo_res_nxt;
  logic [IT_W-1:0]  it_tick_r, it_tick_nxt;

  logic cfg_wr;
  reg_idx_t cfg_idx;
  logic out_load;
  logic in_fire;

  logic [8:0]       hdg_diff;
  logic [31:0]      odo_delta;
  logic             sp_ex, crs, dist_hit;
  chg_t             fchg, lchg;
  logic [BT_W:0]    bo_tick_inc;
  logic             bo_wrap, bo_fire, bo_hit;
  logic [31:0]      bo_count_inc;
  logic [RES_W-1:0] bo_res_inc;
  logic [IT_W:0]    it_tick_inc;
  logic             it_wrap, it_fire;
  logic             pend_track, pend_bo, emit;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_ctrl_r     <= TRACK_CTRL_RST;
      speed_limit_r    <= SPEED_LIMIT_RST;
      heading_limit_r  <= HEADING_LIMIT_RST;
      distance_limit_r <= DISTANCE_LIMIT_RST;
      send_interval_r  <= SEND_INTERVAL_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TRACK_CTRL:     track_ctrl_r     <= cfg_pwdata[0];
        REG_SPEED_LIMIT:    speed_limit_r    <= cfg_pwdata[9:0];
        REG_HEADING_LIMIT:  heading_limit_r  <= cfg_pwdata[8:0];
        REG_DISTANCE_LIMIT: distance_limit_r <= cfg_pwdata[31:0];
        REG_SEND_INTERVAL:  send_interval_r  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TRACK_CTRL:     cfg_prdata = {31'd0, track_ctrl_r};
      REG_SPEED_LIMIT:    cfg_prdata = {22'd0, speed_limit_r};
      REG_HEADING_LIMIT:  cfg_prdata = {23'd0, heading_limit_r};
      REG_DISTANCE_LIMIT: cfg_prdata = distance_limit_r;
      REG_SEND_INTERVAL:  cfg_prdata = {16'd0, send_interval_r};
      default:            cfg_prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  assign out_load     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || out_load;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (out_load) begin
        s1_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_ch.data;
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  // ---------------- tick evaluation ----------------
  always_comb begin
    speed_latched_nxt = speed_latched_r;
    last_heading_nxt  = last_heading_r;
    odo_mark_nxt      = odo_mark_r;
    fix_seen_nxt      = fix_seen_r;
    link_seen_nxt     = link_seen_r;
    sp_ex             = 1'b0;
    crs               = 1'b0;
    dist_hit          = 1'b0;
    fchg              = CHG_NONE;
    lchg              = CHG_NONE;

    hdg_diff  = (last_heading_r > s1_data_r.heading) ? (last_heading_r - s1_data_r.heading)
                                                      : (s1_data_r.heading - last_heading_r);
    odo_delta = s1_data_r.odometer - odo_mark_r;

    if (!s1_data_r.fix_good) begin
      if (fix_seen_r) begin
        fix_seen_nxt = 1'b0;
        fchg         = CHG_LOST;
      end
    end else if (track_ctrl_r) begin
      if (!fix_seen_r) begin
        fix_seen_nxt = 1'b1;
        fchg         = CHG_REGAINED;
      end
      if (s1_data_r.speed > speed_limit_r) begin
        if (!speed_latched_r) begin
          speed_latched_nxt = 1'b1;
          sp_ex             = 1'b1;
        end
      end else if (({1'b0, s1_data_r.speed} + 11'(SPEED_HYST)) < {1'b0, speed_limit_r}) begin
        speed_latched_nxt = 1'b0;
      end
      crs = (s1_data_r.speed > 10'(MOVING_SPEED)) && (hdg_diff > heading_limit_r);
      last_heading_nxt = s1_data_r.heading;
      if (odo_delta > distance_limit_r) begin
        odo_mark_nxt = s1_data_r.odometer;
        dist_hit     = 1'b1;
      end
    end

    if (s1_data_r.link_down) begin
      if (link_seen_r) begin
        link_seen_nxt = 1'b0;
        lchg          = CHG_LOST;
      end
    end else if (!link_seen_r) begin
      link_seen_nxt = 1'b1;
      lchg          = CHG_REGAINED;
    end
  end

  // Backoff: the residue tracks the 32-bit count modulo 30, including the
  // wrap of the count back to zero.
  assign bo_tick_inc  = {1'b0, bo_tick_r} + (BT_W+1)'(1);
  assign bo_wrap      = bo_tick_inc >= (BT_W+1)'(BACKOFF_PERIOD);
  assign bo_fire      = bo_wrap && !s1_data_r.fix_good && !s1_data_r.link_down;
  assign bo_count_inc = bo_count_r + 32'd1;
  assign bo_res_inc   = (bo_count_r == 32'hFFFF_FFFF) ? '0 :
                        (bo_res_r == RES_W'(BACKOFF_MULT - 1)) ? '0 :
                        bo_res_r + RES_W'(1);
  assign bo_hit       = (bo_count_inc == 32'd1) || (bo_count_inc == 32'd2) ||
                        (bo_count_inc == 32'd4) || (bo_count_inc == 32'd8) ||
                        (bo_count_inc == 32'd16) || (bo_res_inc == '0);

  assign it_tick_inc  = {1'b0, it_tick_r} + (IT_W+1)'(1);
  assign it_wrap      = it_tick_inc >= (IT_W+1)'({send_interval_r, 1'b0});
  assign it_fire      = it_wrap && s1_data_r.fix_good;

  always_comb begin
    bo_tick_nxt  = bo_wrap ? '0 : bo_tick_inc[BT_W-1:0];
    bo_count_nxt = bo_count_r;
    bo_res_nxt   = bo_res_r;
    if (bo_fire) begin
      bo_count_nxt = bo_count_inc;
      bo_res_nxt   = bo_res_inc;
    end
    it_tick_nxt = it_wrap ? '0 : it_tick_inc[IT_W-1:0];
    if (it_fire) begin
      bo_count_nxt = '0;
      bo_res_nxt   = '0;
    end
  end

  // A backoff expiry discards whatever was pending this tick, hello included.
  assign pend_track = s1_data_r.hello_request || sp_ex || crs || dist_hit;
  assign pend_bo    = bo_fire ? bo_hit : pend_track;
  assign emit       = it_fire || pend_bo;

  always_comb begin
    out_data_nxt.emit_report     = emit;
    out_data_nxt.speed_exceeded  = sp_ex;
    out_data_nxt.course_changed  = crs;
    out_data_nxt.distance_passed = dist_hit;
    out_data_nxt.fix_lost        = !s1_data_r.fix_good;
    out_data_nxt.link_lost       = s1_data_r.link_down;
    out_data_nxt.fix_change      = fchg;
    out_data_nxt.link_change     = lchg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_latched_r <= 1'b0;
      last_heading_r  <= '0;
      odo_mark_r      <= '0;
      fix_seen_r      <= 1'b0;
      link_seen_r     <= 1'b0;
      bo_tick_r       <= '0;
      bo_count_r      <= '0;
      bo_res_r        <= '0;
      it_tick_r       <= '0;
    end else if (out_load) begin
      speed_latched_r <= speed_latched_nxt;
      last_heading_r  <= last_heading_nxt;
      odo_mark_r      <= odo_mark_nxt;
      fix_seen_r      <= fix_seen_nxt;
      link_seen_r     <= link_seen_nxt;
      bo_tick_r       <= bo_tick_nxt;
      bo_count_r      <= bo_count_nxt;
      bo_res_r        <= bo_res_nxt;
      it_tick_r       <= it_tick_nxt;
    end
  end

  // ---------------- assertions ----------------
  `TRT_ASSERT_NOW(a_res_range, clk, rst_n, 1'b1, bo_res_r < RES_W'(BACKOFF_MULT), "backoff residue out of range")
  `TRT_ASSERT_NOW(a_res_zero, clk, rst_n, bo_count_r == 32'd0, bo_res_r == '0, "residue not zero with zero count")
  `TRT_ASSERT_NOW(a_bo_tick, clk, rst_n, 1'b1, bo_tick_r < BT_W'(BACKOFF_PERIOD), "backoff tick past period")
  `TRT_ASSERT_NEXT(a_state_hold, clk, rst_n, !out_load, $stable(bo_count_r) && $stable(it_tick_r), "state moved without a tick")

endmodule
